// ===== rtl/poram_pkg.sv =====
// ----------------------------------------------------------------------------
// poram_pkg
// Shared types and constants for the path ORAM controller.
// ----------------------------------------------------------------------------
package poram_pkg;

    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_LOAD  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_PMAP,
        ST_PATH_RD,
        ST_PATH_WR,
        ST_FIND,
        ST_SERVE,
        ST_EV_INIT,
        ST_EV_SCAN,
        ST_EV_LOOK,
        ST_EV_MOVE,
        ST_EV_PAD,
        ST_DONE
    } t_state;

endpackage

// ===== rtl/path_oram_access_controller.sv =====
// ----------------------------------------------------------------------------
// path_oram_access_controller
// Path ORAM with binary bucket tree, position map and internal stash.
// ----------------------------------------------------------------------------
// Flow: a load or an ignored item goes from idle straight to the done state, which
//   registers its result; an access reads and rewrites the path, and its length is
//   set by the single-port tree memory and the stash scan done once per level, each
//   entry through the scan, look and move states, via one stash read port. One item
//   at a time: input stalls until the result has been taken.
// Reset: synchronous, active low; a clearing pass writes every tree slot empty and
//   every position map entry to leaf 0, one address a cycle over
//   max(BUCKET_SLOTS*(2^TREE_LEVELS-1), BLOCK_COUNT) addresses, before any item.
// ----------------------------------------------------------------------------
module path_oram_access_controller import poram_pkg::*; #(
    parameter int BLOCK_COUNT  = 64,
    parameter int TREE_LEVELS  = 7,
    parameter int BUCKET_SLOTS = 4,
    parameter int STASH_DEPTH  = 64,
    parameter int BLOCK_WORDS  = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_command,
    input  logic [5:0]  i_block_index,
    input  logic [5:0]  i_new_leaf,
    input  logic [63:0] i_write_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_read_data,
    output logic        o_hit,
    output logic [6:0]  o_stash_count,
    output logic [6:0]  o_stash_peak,
    output logic        o_stash_overflow
);
    localparam int BUCKETS = (1 << TREE_LEVELS) - 1;
    localparam int SLOTS   = BUCKETS * BUCKET_SLOTS;
    localparam int SAW     = $clog2(SLOTS);
    localparam int LW      = TREE_LEVELS - 1;          // leaf bits
    localparam int LVW     = $clog2(TREE_LEVELS + 1);
    localparam int ZW      = $clog2(BUCKET_SLOTS + 1);
    localparam int BW      = $clog2(BLOCK_COUNT);
    localparam int TTW     = BW + 1;                    // tree tag: 0 empty, else idx+1
    localparam int SDW     = $clog2(STASH_DEPTH);
    localparam int SCW     = SDW + 1;
    localparam int PMW     = (LW > 0) ? LW : 1;
    localparam int CLR_N   = (SLOTS > BLOCK_COUNT) ? SLOTS : BLOCK_COUNT;
    localparam int CLW     = $clog2(CLR_N);
    localparam logic [63:0] PAY_MASK = (BLOCK_WORDS >= 2) ? {64{1'b1}} : 64'hFFFF_FFFF;

    t_state r_state, n_state;

    // item registers
    logic [1:0]     r_cmd;
    logic [5:0]     r_idx;
    logic [PMW-1:0] r_leaf;
    logic [63:0]    r_wdata;
    logic [PMW-1:0] r_old_leaf;
    // counters
    logic [LVW-1:0] r_lv;
    logic [ZW-1:0]  r_slot;
    logic [SCW-1:0] r_i, r_kept, r_fill, r_peak;
    logic [ZW-1:0]  r_placed;
    logic           r_ovf, r_hit, r_found, r_rvalid;
    logic [SDW-1:0] r_found_at;
    logic [CLW-1:0] r_clr;
    logic [63:0]    r_rdata;
    // results
    logic           r_ovalid;
    logic [63:0]    r_o_rdata;
    logic           r_o_hit;

    // position map: small memory with a registered read port and a separate write port
    logic [PMW-1:0] r_pmap [BLOCK_COUNT];
    logic [PMW-1:0] pm_rd;
    logic [BW-1:0]  pm_raddr;
    logic           pm_we;
    logic [BW-1:0]  pm_waddr;
    logic [PMW-1:0] pm_wdata;

    always_ff @(posedge i_clk) begin
        if (pm_we) r_pmap[pm_waddr] <= pm_wdata;
        pm_rd <= r_pmap[pm_raddr];
    end

    // tree memory
    logic           t_we;
    logic [SAW-1:0] t_addr;
    logic [TTW-1:0] t_wtag, t_rtag;
    logic [63:0]    t_wdata, t_rdata;
    poram_tree_mem #(.DEPTH(SLOTS), .AW(SAW), .TW(TTW)) u_tree (
        .i_clk(i_clk), .i_we(t_we), .i_addr(t_addr), .i_wtag(t_wtag),
        .i_wdata(t_wdata), .o_rtag(t_rtag), .o_rdata(t_rdata)
    );

    // stash memory
    logic           s_we;
    logic [SDW-1:0] s_waddr, s_raddr;
    logic [BW-1:0]  s_wtag, s_rtag;
    logic [63:0]    s_wdata, s_rdata;
    poram_stash_mem #(.DEPTH(STASH_DEPTH), .AW(SDW), .TW(BW)) u_stash (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_waddr), .i_wtag(s_wtag),
        .i_wdata(s_wdata), .i_raddr(s_raddr), .o_rtag(s_rtag), .o_rdata(s_rdata)
    );

    // bucket index at level lv on leaf f: (2^lv - 1) + (f >> (L-1-lv))
    function automatic logic [SAW-1:0] slot_base(input logic [PMW-1:0] f,
                                                 input logic [LVW-1:0] lv);
        logic [SAW-1:0] bk;
        bk = SAW'((SAW'(1) << lv) - SAW'(1)) +
             SAW'(({1'b0, f} >> (LVW'(TREE_LEVELS - 1) - lv)));
        return SAW'(bk * SAW'(BUCKET_SLOTS));
    endfunction

    logic accept;
    assign accept  = i_valid && !o_stall;
    assign o_stall = (r_state != ST_IDLE) || r_ovalid;

    // eviction match: compare the path prefix of the stash block's leaf
    logic [PMW-1:0] diff;
    logic           match;
    assign diff  = pm_rd ^ r_old_leaf;
    assign match = ((diff >> (LVW'(TREE_LEVELS - 1) - r_lv)) == '0);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR:   if (r_clr == CLW'(CLR_N - 1)) n_state = ST_IDLE;
            ST_IDLE: begin
                if (accept) begin
                    if (BW'(i_block_index) != i_block_index[BW-1:0] ||
                        32'(i_block_index) >= BLOCK_COUNT)
                        n_state = ST_DONE;
                    else if (i_command == CMD_LOAD || i_command == 2'd3)
                        n_state = ST_DONE;
                    else
                        n_state = ST_PMAP;
                end
            end
            ST_PMAP:    n_state = ST_PATH_RD;
            ST_PATH_RD: n_state = ST_PATH_WR;
            ST_PATH_WR: begin
                if (r_slot == ZW'(BUCKET_SLOTS - 1) && r_lv == LVW'(TREE_LEVELS - 1))
                    n_state = ST_FIND;
                else
                    n_state = ST_PATH_RD;
            end
            ST_FIND:    if (r_i == r_fill || r_found) n_state = ST_SERVE;
            ST_SERVE:   n_state = ST_EV_INIT;
            ST_EV_INIT: n_state = ST_EV_SCAN;
            ST_EV_SCAN: n_state = (r_i == r_fill) ? ST_EV_PAD : ST_EV_LOOK;
            ST_EV_LOOK: n_state = ST_EV_MOVE;
            ST_EV_MOVE: n_state = ST_EV_SCAN;
            ST_EV_PAD: begin
                if (r_placed == ZW'(BUCKET_SLOTS))
                    n_state = (r_lv == '0) ? ST_DONE : ST_EV_INIT;
            end
            ST_DONE:    n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // memory controls
    always_comb begin
        pm_raddr = r_idx[BW-1:0];
        pm_we    = 1'b0;
        pm_waddr = r_idx[BW-1:0];
        pm_wdata = r_leaf;
        t_we     = 1'b0;
        t_addr   = slot_base(r_old_leaf, r_lv) + SAW'(r_slot);
        t_wtag   = '0;
        t_wdata  = '0;
        s_we     = 1'b0;
        s_waddr  = r_fill[SDW-1:0];
        s_wtag   = t_rtag[BW-1:0] - BW'(1);
        s_wdata  = t_rdata;
        s_raddr  = r_i[SDW-1:0];
        case (r_state)
            ST_CLEAR: begin
                // empty tree slots and leaf 0 for every block
                t_we     = (32'(r_clr) < SLOTS);
                t_addr   = r_clr[SAW-1:0];
                pm_we    = (32'(r_clr) < BLOCK_COUNT);
                pm_waddr = r_clr[BW-1:0];
                pm_wdata = '0;
            end
            ST_IDLE: begin
                pm_raddr = i_block_index[BW-1:0];
                pm_waddr = i_block_index[BW-1:0];
                pm_wdata = PMW'(i_new_leaf);
                pm_we    = accept && i_command == CMD_LOAD &&
                           32'(i_block_index) < BLOCK_COUNT;
            end
            ST_PMAP: pm_we = 1'b1;
            ST_PATH_WR: begin
                t_we = 1'b1;
                s_we = (t_rtag != '0) && (r_fill != SCW'(STASH_DEPTH));
            end
            ST_SERVE: begin
                if (r_found) begin
                    s_we    = (r_cmd == CMD_WRITE);
                    s_waddr = r_found_at;
                    s_wtag  = r_idx[BW-1:0];
                    s_wdata = r_wdata;
                end else if (r_cmd == CMD_WRITE && r_fill != SCW'(STASH_DEPTH)) begin
                    s_we    = 1'b1;
                    s_wtag  = r_idx[BW-1:0];
                    s_wdata = r_wdata;
                end
            end
            // stash entry is out now; look up its leaf for the move cycle
            ST_EV_LOOK: pm_raddr = s_rtag;
            ST_EV_MOVE: begin
                if (match && r_placed != ZW'(BUCKET_SLOTS)) begin
                    t_we    = 1'b1;
                    t_addr  = slot_base(r_old_leaf, r_lv) + SAW'(r_placed);
                    t_wtag  = TTW'(s_rtag) + TTW'(1);
                    t_wdata = s_rdata;
                end else begin
                    s_we    = 1'b1;
                    s_waddr = r_kept[SDW-1:0];
                    s_wtag  = s_rtag;
                    s_wdata = s_rdata;
                end
            end
            ST_EV_PAD: begin
                t_we   = (r_placed != ZW'(BUCKET_SLOTS));
                t_addr = slot_base(r_old_leaf, r_lv) + SAW'(r_placed);
            end
            default: ;
        endcase
    end

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_fill   <= '0;
            r_peak   <= '0;
            r_ovf    <= 1'b0;
            r_ovalid <= 1'b0;
            r_rvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rvalid <= 1'b0;
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            case (r_state)
                ST_CLEAR: r_clr <= r_clr + CLW'(1);
                ST_IDLE: begin
                    if (accept) begin
                        r_cmd   <= i_command;
                        r_idx   <= i_block_index;
                        r_leaf  <= PMW'(i_new_leaf);
                        r_wdata <= i_write_data & PAY_MASK;
                        r_hit   <= 1'b0;
                        r_rdata <= '0;
                        r_lv    <= '0;
                        r_slot  <= '0;
                    end
                end
                ST_PMAP: r_old_leaf <= pm_rd;
                ST_PATH_WR: begin
                    if (t_rtag != '0) begin
                        if (r_fill != SCW'(STASH_DEPTH)) r_fill <= r_fill + SCW'(1);
                        else r_ovf <= 1'b1;
                    end
                    if (r_slot == ZW'(BUCKET_SLOTS - 1)) begin
                        r_slot <= '0;
                        if (r_lv != LVW'(TREE_LEVELS - 1)) r_lv <= r_lv + LVW'(1);
                        else begin
                            r_i     <= '0;
                            r_found <= 1'b0;
                        end
                    end else r_slot <= r_slot + ZW'(1);
                end
                ST_FIND: begin
                    // stash read is registered, so its data lags the address
                    r_rvalid <= (r_i != r_fill) && !r_rvalid && !r_found;
                    if (r_rvalid) begin
                        if (s_rtag == r_idx[BW-1:0]) begin
                            r_found    <= 1'b1;
                            r_found_at <= r_i[SDW-1:0];
                        end else r_i <= r_i + SCW'(1);
                    end
                end
                ST_SERVE: begin
                    logic [SCW-1:0] f;
                    f = r_fill;
                    if (r_found) begin
                        r_hit <= 1'b1;
                        if (r_cmd != CMD_WRITE) r_rdata <= s_rdata;
                    end else if (r_cmd == CMD_WRITE) begin
                        if (r_fill != SCW'(STASH_DEPTH)) f = r_fill + SCW'(1);
                        else r_ovf <= 1'b1;
                    end
                    r_fill <= f;
                    if (f > r_peak) r_peak <= f;
                    r_lv <= LVW'(TREE_LEVELS - 1);
                end
                ST_EV_INIT: begin
                    r_i      <= '0;
                    r_kept   <= '0;
                    r_placed <= '0;
                end
                ST_EV_MOVE: begin
                    if (match && r_placed != ZW'(BUCKET_SLOTS))
                        r_placed <= r_placed + ZW'(1);
                    else r_kept <= r_kept + SCW'(1);
                    r_i <= r_i + SCW'(1);
                end
                ST_EV_PAD: begin
                    r_fill <= r_kept;
                    if (r_placed != ZW'(BUCKET_SLOTS)) r_placed <= r_placed + ZW'(1);
                    else if (r_lv != '0) r_lv <= r_lv - LVW'(1);
                end
                ST_DONE: begin
                    r_ovalid  <= 1'b1;
                    r_o_rdata <= r_rdata;
                    r_o_hit   <= r_hit;
                end
                default: ;
            endcase
        end
    end

    assign o_valid          = r_ovalid;
    assign o_read_data      = r_o_rdata;
    assign o_hit            = r_o_hit;
    assign o_stash_count    = 7'(r_fill);
    assign o_stash_peak     = 7'(r_peak);
    assign o_stash_overflow = r_ovf;
endmodule

// ===== rtl/poram_tree_mem.sv =====
// ----------------------------------------------------------------------------
// poram_tree_mem
// Bucket tree slot store: tag plus payload, one port, registered read.
// ----------------------------------------------------------------------------
module poram_tree_mem import poram_pkg::*; #(
    parameter int DEPTH = 508,
    parameter int AW    = 9,
    parameter int TW    = 7
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic [TW-1:0] i_wtag,
    input  logic [63:0]   i_wdata,
    output logic [TW-1:0] o_rtag,
    output logic [63:0]   o_rdata
);
    logic [TW-1:0] r_tag [DEPTH];
    logic [63:0]   r_pay [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_tag[i_addr] <= i_wtag;
            r_pay[i_addr] <= i_wdata;
        end
        o_rtag  <= r_tag[i_addr];
        o_rdata <= r_pay[i_addr];
    end
endmodule

// ===== rtl/poram_stash_mem.sv =====
// ----------------------------------------------------------------------------
// poram_stash_mem
// Stash store: one write port and one registered read port.
// ----------------------------------------------------------------------------
module poram_stash_mem import poram_pkg::*; #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int TW    = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [TW-1:0] i_wtag,
    input  logic [63:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [TW-1:0] o_rtag,
    output logic [63:0]   o_rdata
);
    logic [TW-1:0] r_tag [DEPTH];
    logic [63:0]   r_pay [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_tag[i_waddr] <= i_wtag;
            r_pay[i_waddr] <= i_wdata;
        end
        o_rtag  <= r_tag[i_raddr];
        o_rdata <= r_pay[i_raddr];
    end
endmodule
